FILE: sv/sm4_pkg.sv
package sm4_pkg;

  localparam int unsigned Rounds    = 32;
  localparam int unsigned RndW      = $clog2(Rounds);
  localparam int unsigned MaxRepeat = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned RepeatW   = 5;

  localparam logic [127:0] Fk = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH,
    REG_KEY_LOW,
    REG_IV_HIGH,
    REG_IV_LOW,
    REG_CHAIN_MODE,
    REG_DIRECTION,
    REG_REPEAT_COUNT
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_KEY_LOAD,
    ST_KEY_EXP,
    ST_IDLE,
    ST_FETCH,
    ST_ROUND,
    ST_DONE
  } state_e;

  localparam logic [7:0] Sbox [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] ck_word(logic [RndW-1:0] i);
    logic [31:0] w;
    logic [7:0]  b;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'({i, 2'(j)}) * 8'd7;
      w = {w[23:0], b};
    end
    return w;
  endfunction

endpackage

FILE: sv/sm4_ifs.sv
interface sm4_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        new_message;

  modport source (output valid, block_high, block_low, new_message, input ready);
  modport sink   (input valid, block_high, block_low, new_message, output ready);
endinterface

interface sm4_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;

  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

FILE: sv/sm4_tfn.sv
module sm4_tfn (
  input  logic [31:0] word_i,
  input  logic        key_sched_i,
  output logic [31:0] word_o
);

  logic [31:0] sub;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sub[8*i +: 8] = sm4_pkg::Sbox[word_i[8*i +: 8]];
    end
  end

  always_comb begin
    if (key_sched_i) begin
      word_o = sub ^ sm4_pkg::rotl(sub, 13) ^ sm4_pkg::rotl(sub, 23);
    end else begin
      word_o = sub ^ sm4_pkg::rotl(sub, 2) ^ sm4_pkg::rotl(sub, 10)
             ^ sm4_pkg::rotl(sub, 18) ^ sm4_pkg::rotl(sub, 24);
    end
  end

endmodule

FILE: sv/sm4_block_cipher_ecb_cbc.sv
// Channel   Dir  Payload                                 Handshake
// in_ch     in   block_high, block_low, new_message      valid/ready
// out_ch    out  result_high, result_low                 valid/ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i         write on cfg_we_i
//
// Each item is fetched and then runs 32 rounds per pass in the shared round unit,
// one round per cycle; the DONE state then hands the result to the output register.
// Key expansion runs after reset and after every key write; in_ch is not ready then.
// The next item is taken while a result waits in the output register; a stalled
// output holds the finished item until the register frees.
module sm4_block_cipher_ecb_cbc #(
  parameter int unsigned MAX_REPEAT = sm4_pkg::MaxRepeat
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sm4_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sm4_pkg::CfgDataW-1:0]   cfg_data_i,
  sm4_in_if.sink                         in_ch,
  sm4_out_if.source                      out_ch
);

  localparam int unsigned RndW    = sm4_pkg::RndW;
  localparam int unsigned RepW    = sm4_pkg::RepeatW;
  localparam int unsigned MaxPass = (MAX_REPEAT < 31) ? MAX_REPEAT : 31;
  localparam logic [RepW-1:0] MaxPassW = RepW'(MaxPass);
  localparam logic [RndW-1:0] LastRnd  = RndW'(sm4_pkg::Rounds - 1);

  sm4_pkg::state_e state_q, state_d;

  logic [63:0]      key_high_q, key_low_q, iv_high_q, iv_low_q;
  logic             cbc_q, dec_q;
  logic [RepW-1:0]  rep_q;
  logic [127:0]     chain_q;
  logic [127:0]     k_q, x_q, blk_q;
  logic [31:0]      rk_q;
  logic [31:0]      rk_mem [sm4_pkg::Rounds];
  logic [RndW-1:0]  cnt_q;
  logic [RepW-1:0]  pass_q;
  logic             out_valid_q;
  logic [127:0]     res_q;

  logic             key_wr, accept, out_free;
  logic             in_ready, ld_item, out_load;
  logic [RndW-1:0]  rd_base, rd_addr;
  logic [RepW-1:0]  passes;
  logic             last_rnd, last_pass;
  logic [31:0]      t_in, t_out, nk, nx;
  logic [127:0]     in_blk, chain_eff;

  assign key_wr = cfg_we_i && (cfg_idx_i == sm4_pkg::REG_KEY_HIGH
                               || cfg_idx_i == sm4_pkg::REG_KEY_LOW);
  assign accept    = in_ch.valid && in_ready;
  assign out_free  = !out_valid_q || out_ch.ready;
  assign in_blk    = {in_ch.block_high, in_ch.block_low};
  assign chain_eff = in_ch.new_message ? {iv_high_q, iv_low_q} : chain_q;
  assign passes    = (rep_q == '0) ? RepW'(1) : ((rep_q > MaxPassW) ? MaxPassW : rep_q);
  assign last_rnd  = cnt_q == LastRnd;
  assign last_pass = pass_q == passes - RepW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      sm4_pkg::ST_KEY_LOAD: state_d = sm4_pkg::ST_KEY_EXP;
      sm4_pkg::ST_KEY_EXP:  if (last_rnd) state_d = sm4_pkg::ST_IDLE;
      sm4_pkg::ST_IDLE:     if (accept) state_d = sm4_pkg::ST_FETCH;
      sm4_pkg::ST_FETCH:    state_d = sm4_pkg::ST_ROUND;
      sm4_pkg::ST_ROUND:    if (last_rnd && last_pass) state_d = sm4_pkg::ST_DONE;
      sm4_pkg::ST_DONE:     if (out_free) state_d = sm4_pkg::ST_IDLE;
      default:              state_d = sm4_pkg::ST_KEY_LOAD;
    endcase
    if (key_wr) begin
      state_d = sm4_pkg::ST_KEY_LOAD;
    end
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    rd_base  = '0;
    case (state_q)
      sm4_pkg::ST_IDLE:  in_ready = 1'b1;
      sm4_pkg::ST_ROUND: rd_base  = cnt_q + RndW'(1);
      sm4_pkg::ST_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  assign ld_item = accept;
  assign rd_addr = dec_q ? ~rd_base : rd_base;

  always_comb begin
    if (state_q == sm4_pkg::ST_KEY_EXP) begin
      t_in = k_q[95:64] ^ k_q[63:32] ^ k_q[31:0] ^ sm4_pkg::ck_word(cnt_q);
    end else begin
      t_in = x_q[95:64] ^ x_q[63:32] ^ x_q[31:0] ^ rk_q;
    end
  end

  sm4_tfn u_tfn (
    .word_i      (t_in),
    .key_sched_i (state_q == sm4_pkg::ST_KEY_EXP),
    .word_o      (t_out)
  );

  assign nk = k_q[127:96] ^ t_out;
  assign nx = x_q[127:96] ^ t_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sm4_pkg::ST_KEY_LOAD;
      key_high_q  <= '0;
      key_low_q   <= '0;
      iv_high_q   <= '0;
      iv_low_q    <= '0;
      cbc_q       <= 1'b0;
      dec_q       <= 1'b0;
      rep_q       <= RepW'(1);
      chain_q     <= '0;
      cnt_q       <= '0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sm4_pkg::REG_KEY_HIGH:     key_high_q <= cfg_data_i;
          sm4_pkg::REG_KEY_LOW:      key_low_q  <= cfg_data_i;
          sm4_pkg::REG_IV_HIGH:      iv_high_q  <= cfg_data_i;
          sm4_pkg::REG_IV_LOW:       iv_low_q   <= cfg_data_i;
          sm4_pkg::REG_CHAIN_MODE:   cbc_q      <= cfg_data_i[0];
          sm4_pkg::REG_DIRECTION:    dec_q      <= cfg_data_i[0];
          sm4_pkg::REG_REPEAT_COUNT: rep_q      <= cfg_data_i[RepW-1:0];
          default: ;
        endcase
      end
      case (state_q)
        sm4_pkg::ST_KEY_LOAD: cnt_q <= '0;
        sm4_pkg::ST_KEY_EXP:  cnt_q <= cnt_q + RndW'(1);
        sm4_pkg::ST_FETCH: begin
          cnt_q  <= '0;
          pass_q <= '0;
        end
        sm4_pkg::ST_ROUND: begin
          cnt_q <= cnt_q + RndW'(1);
          if (last_rnd) begin
            pass_q <= pass_q + RepW'(1);
          end
        end
        default: ;
      endcase
      if (ld_item && in_ch.new_message) begin
        chain_q <= {iv_high_q, iv_low_q};
      end else if (out_load && cbc_q) begin
        chain_q <= dec_q ? blk_q : x_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rk_q <= rk_mem[rd_addr];
    if (state_q == sm4_pkg::ST_KEY_EXP) begin
      rk_mem[cnt_q] <= nk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sm4_pkg::ST_KEY_LOAD) begin
      k_q <= {key_high_q, key_low_q} ^ sm4_pkg::Fk;
    end else if (state_q == sm4_pkg::ST_KEY_EXP) begin
      k_q <= {k_q[95:0], nk};
    end
    if (ld_item) begin
      blk_q <= in_blk;
      x_q   <= in_blk ^ ((cbc_q && !dec_q) ? chain_eff : '0);
    end else if (state_q == sm4_pkg::ST_ROUND) begin
      x_q <= last_rnd ? {nx, x_q[31:0], x_q[63:32], x_q[95:64]} : {x_q[95:0], nx};
    end
    if (out_load) begin
      res_q <= x_q ^ ((cbc_q && dec_q) ? chain_q : '0);
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_q;
  assign out_ch.result_high = res_q[127:64];
  assign out_ch.result_low  = res_q[63:0];

`ifndef NO_ASSERTIONS
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == sm4_pkg::ST_DONE))
    else $error("result appeared without a finished item");

  a_key_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_wr |=> !in_ch.ready)
    else $error("input ready during key expansion");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sm4_pkg::ST_ROUND |-> pass_q < passes)
    else $error("pass counter past repeat count");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sm4_pkg::ST_DONE && !out_free && !key_wr |=> state_q == sm4_pkg::ST_DONE)
    else $error("finished item dropped while output stalled");
`endif

endmodule

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned                    ItemTarget  = 1300;
  localparam int unsigned                    MaxIdle     = 17;
  localparam int unsigned                    MaxPasses   = 16;
  localparam int unsigned                    MaxReports  = 10;
  localparam int unsigned                    DrainCycles = 600;
  localparam longint unsigned                TimeoutNs   = 64'd8_000_000;
  localparam logic [sm4_pkg::CfgIdxW-1:0]    RegSpare    = 3'd7;

  localparam logic [7:0] SubTable [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  typedef struct {
    bit                           is_cfg;
    logic [sm4_pkg::CfgIdxW-1:0]  idx;
    logic [sm4_pkg::CfgDataW-1:0] data;
    logic [63:0]                  blk_hi;
    logic [63:0]                  blk_lo;
    logic                         new_msg;
  } stim_op_t;

  typedef struct {
    logic [63:0] res_hi;
    logic [63:0] res_lo;
  } cipher_out_t;

  typedef enum logic [1:0] {
    KEY_READY,
    KEY_WAIT_DROP,
    KEY_WAIT_RISE
  } key_wait_e;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [sm4_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [sm4_pkg::CfgDataW-1:0] cfg_data_i;

  sm4_in_if  in_if ();
  sm4_out_if out_if ();

  sm4_block_cipher_ecb_cbc dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_if),
    .out_ch     (out_if)
  );

  stim_op_t    stim_ops [$];
  cipher_out_t cipher_outs [$];
  int unsigned blocks_queued;
  int unsigned blocks_sent;
  int unsigned results_seen;
  int unsigned fail_count;
  int unsigned gap_left;
  int unsigned stall_left;
  key_wait_e   key_wait;

  logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic         cbc_q, decrypt_q;
  logic [4:0]   passes_q;
  logic [127:0] chain_q;
  logic [31:0]  rkeys [32];

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic logic [31:0] rol(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] tau_sub(logic [31:0] x);
    return {SubTable[x[31:24]], SubTable[x[23:16]], SubTable[x[15:8]], SubTable[x[7:0]]};
  endfunction

  function automatic void schedule_keys();
    logic [31:0] k [4];
    logic [31:0] t;
    logic [31:0] ck;
    k[0] = key_hi_q[63:32] ^ 32'ha3b1bac6;
    k[1] = key_hi_q[31:0]  ^ 32'h56aa3350;
    k[2] = key_lo_q[63:32] ^ 32'h677d9197;
    k[3] = key_lo_q[31:0]  ^ 32'hb27022dc;
    for (int i = 0; i < 32; i++) begin
      ck = '0;
      for (int j = 0; j < 4; j++) ck = {ck[23:0], 8'((4 * i + j) * 7)};
      t = tau_sub(k[1] ^ k[2] ^ k[3] ^ ck);
      rkeys[i] = k[0] ^ t ^ rol(t, 13) ^ rol(t, 23);
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = rkeys[i];
    end
  endfunction

  function automatic logic [127:0] sm4_transform(logic [127:0] blk, logic dec);
    logic [31:0] x [4];
    logic [31:0] t;
    logic [31:0] nx;
    x[0] = blk[127:96];
    x[1] = blk[95:64];
    x[2] = blk[63:32];
    x[3] = blk[31:0];
    for (int i = 0; i < 32; i++) begin
      t = tau_sub(x[1] ^ x[2] ^ x[3] ^ rkeys[dec ? 31 - i : i]);
      nx = x[0] ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nx;
    end
    return {x[3], x[2], x[1], x[0]};
  endfunction

  function automatic void write_shadow(logic [sm4_pkg::CfgIdxW-1:0] idx,
                                       logic [sm4_pkg::CfgDataW-1:0] data);
    case (idx)
      sm4_pkg::REG_KEY_HIGH: begin
        key_hi_q = data;
        schedule_keys();
      end
      sm4_pkg::REG_KEY_LOW: begin
        key_lo_q = data;
        schedule_keys();
      end
      sm4_pkg::REG_IV_HIGH:      iv_hi_q = data;
      sm4_pkg::REG_IV_LOW:       iv_lo_q = data;
      sm4_pkg::REG_CHAIN_MODE:   cbc_q = data[0];
      sm4_pkg::REG_DIRECTION:    decrypt_q = data[0];
      sm4_pkg::REG_REPEAT_COUNT: passes_q = data[4:0];
      default: ;
    endcase
  endfunction

  function automatic void crypt_block(logic [63:0] hi, logic [63:0] lo, logic new_msg);
    logic [127:0] blk;
    int unsigned  passes;
    passes = (passes_q == 0) ? 1 : ((passes_q > MaxPasses) ? MaxPasses : passes_q);
    if (new_msg) chain_q = {iv_hi_q, iv_lo_q};
    blk = {hi, lo};
    if (cbc_q && !decrypt_q) blk ^= chain_q;
    for (int p = 0; p < passes; p++) blk = sm4_transform(blk, decrypt_q);
    if (cbc_q) begin
      if (decrypt_q) begin
        blk ^= chain_q;
        chain_q = {hi, lo};
      end else begin
        chain_q = blk;
      end
    end
    cipher_outs.push_back('{res_hi: blk[127:64], res_lo: blk[63:0]});
  endfunction

  function automatic void log_fail(string msg);
    if (fail_count < MaxReports) $display("ERROR: %s", msg);
    fail_count++;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  function automatic logic [4:0] pick_passes();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 5'd1;
    if (r < 80) return 5'($urandom_range(2, 3));
    if (r < 88) return 5'($urandom_range(0, 8));
    if (r < 96) return 5'($urandom_range(9, 15));
    return 5'($urandom_range(16, 31));
  endfunction

  function automatic int unsigned pick_idle(int unsigned count);
    if ((count / 40) % 5 == 0) return 0;
    return $urandom_range(0, MaxIdle);
  endfunction

  function automatic void put_cfg(logic [sm4_pkg::CfgIdxW-1:0] idx,
                                  logic [sm4_pkg::CfgDataW-1:0] data);
    stim_ops.push_back('{is_cfg: 1'b1, idx: idx, data: data, blk_hi: '0, blk_lo: '0,
                         new_msg: 1'b0});
  endfunction

  function automatic void put_block(logic [63:0] hi, logic [63:0] lo, logic new_msg);
    stim_ops.push_back('{is_cfg: 1'b0, idx: '0, data: '0, blk_hi: hi, blk_lo: lo,
                         new_msg: new_msg});
    blocks_queued++;
  endfunction

  always @(posedge clk_i) begin : drive_items
    logic     offer;
    logic     we;
    stim_op_t head;
    if (rst_ni) begin
      offer = in_if.valid;
      we = 1'b0;
      if (cfg_we_i && (cfg_idx_i == sm4_pkg::REG_KEY_HIGH
                       || cfg_idx_i == sm4_pkg::REG_KEY_LOW)) begin
        key_wait = KEY_WAIT_DROP;
      end else if (key_wait == KEY_WAIT_DROP && !in_if.ready) begin
        key_wait = KEY_WAIT_RISE;
      end else if (key_wait == KEY_WAIT_RISE && in_if.ready) begin
        key_wait = KEY_READY;
      end
      if (in_if.valid && in_if.ready) begin
        crypt_block(in_if.block_high, in_if.block_low, in_if.new_message);
        offer = 1'b0;
        blocks_sent++;
        gap_left = pick_idle(blocks_sent);
      end
      if (!offer && stim_ops.size() != 0) begin
        head = stim_ops[0];
        if (head.is_cfg) begin
          if (key_wait == KEY_READY && cipher_outs.size() == 0) begin
            we = 1'b1;
            cfg_idx_i <= head.idx;
            cfg_data_i <= head.data;
            write_shadow(head.idx, head.data);
            void'(stim_ops.pop_front());
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          offer = 1'b1;
          in_if.block_high <= head.blk_hi;
          in_if.block_low <= head.blk_lo;
          in_if.new_message <= head.new_msg;
          void'(stim_ops.pop_front());
        end
      end
      in_if.valid <= offer;
      cfg_we_i <= we;
    end
  end

  always @(posedge clk_i) begin : check_results
    cipher_out_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (cipher_outs.size() == 0) begin
          log_fail($sformatf("unexpected result %h_%h", out_if.result_high, out_if.result_low));
        end else begin
          want = cipher_outs.pop_front();
          if (out_if.result_high !== want.res_hi) begin
            log_fail($sformatf("result_high expected %h got %h", want.res_hi,
                               out_if.result_high));
          end
          if (out_if.result_low !== want.res_lo) begin
            log_fail($sformatf("result_low expected %h got %h", want.res_lo,
                               out_if.result_low));
          end
        end
        results_seen++;
        stall_left = pick_idle(results_seen);
      end else if (out_if.valid && stall_left != 0) begin
        stall_left--;
      end
      out_if.ready <= (stall_left == 0);
    end
  end

  initial begin : run_test
    int unsigned n;
    logic [63:0] w;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = sm4_pkg::REG_KEY_HIGH;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.block_high = '0;
    in_if.block_low = '0;
    in_if.new_message = 1'b0;
    out_if.ready = 1'b0;
    key_wait = KEY_WAIT_DROP;
    gap_left = 0;
    stall_left = 0;
    key_hi_q = '0;
    key_lo_q = '0;
    iv_hi_q = '0;
    iv_lo_q = '0;
    cbc_q = 1'b0;
    decrypt_q = 1'b0;
    passes_q = 5'd1;
    chain_q = '0;
    schedule_keys();

    put_block('0, '0, 1'b0);
    put_block('1, '1, 1'b1);
    put_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
    put_cfg(sm4_pkg::REG_KEY_HIGH, 64'h0123456789abcdef);
    put_cfg(sm4_pkg::REG_KEY_LOW, 64'hfedcba9876543210);
    put_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
    put_block('1, '0, 1'b0);
    put_cfg(sm4_pkg::REG_DIRECTION, 64'h1);
    put_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b0);
    put_cfg(sm4_pkg::REG_DIRECTION, 64'hffff_ffff_ffff_fffe);
    put_cfg(sm4_pkg::REG_REPEAT_COUNT, '0);
    put_block(rand64(), rand64(), 1'b0);
    put_cfg(sm4_pkg::REG_REPEAT_COUNT, '1);
    put_block(rand64(), rand64(), 1'b0);
    put_cfg(sm4_pkg::REG_REPEAT_COUNT, 64'(MaxPasses + 1));
    put_block(rand64(), rand64(), 1'b0);
    put_cfg(sm4_pkg::REG_REPEAT_COUNT, 64'(MaxPasses));
    put_block(rand64(), rand64(), 1'b0);
    put_cfg(sm4_pkg::REG_REPEAT_COUNT, 64'h1);
    put_cfg(sm4_pkg::REG_IV_HIGH, 64'h0001020304050607);
    put_cfg(sm4_pkg::REG_IV_LOW, 64'h08090a0b0c0d0e0f);
    put_cfg(sm4_pkg::REG_CHAIN_MODE, 64'h1);
    put_block(rand64(), rand64(), 1'b1);
    put_block(rand64(), rand64(), 1'b0);
    put_block(rand64(), rand64(), 1'b0);
    put_cfg(sm4_pkg::REG_DIRECTION, 64'h1);
    put_block(rand64(), rand64(), 1'b1);
    put_block(rand64(), rand64(), 1'b0);
    put_block(rand64(), rand64(), 1'b0);
    // reload of the chain in ECB, then use it in CBC
    put_cfg(sm4_pkg::REG_CHAIN_MODE, 64'h0);
    put_cfg(sm4_pkg::REG_DIRECTION, 64'h0);
    put_cfg(sm4_pkg::REG_IV_HIGH, '1);
    put_cfg(sm4_pkg::REG_IV_LOW, 64'h5555_aaaa_0f0f_f0f0);
    put_block(rand64(), rand64(), 1'b1);
    put_cfg(sm4_pkg::REG_CHAIN_MODE, 64'h1);
    put_block(rand64(), rand64(), 1'b0);
    put_cfg(RegSpare, '1);
    put_block(rand64(), rand64(), 1'b0);

    while (blocks_queued < ItemTarget) begin
      if ($urandom_range(0, 3) == 0) put_cfg(sm4_pkg::REG_KEY_HIGH, pick64());
      if ($urandom_range(0, 3) == 0) put_cfg(sm4_pkg::REG_KEY_LOW, pick64());
      if ($urandom_range(0, 2) == 0) put_cfg(sm4_pkg::REG_IV_HIGH, pick64());
      if ($urandom_range(0, 2) == 0) put_cfg(sm4_pkg::REG_IV_LOW, pick64());
      if ($urandom_range(0, 1) == 0) put_cfg(sm4_pkg::REG_CHAIN_MODE, rand64());
      if ($urandom_range(0, 1) == 0) put_cfg(sm4_pkg::REG_DIRECTION, rand64());
      if ($urandom_range(0, 2) == 0) begin
        w = rand64();
        put_cfg(sm4_pkg::REG_REPEAT_COUNT, {w[63:5], pick_passes()});
      end
      if ($urandom_range(0, 15) == 0) put_cfg(RegSpare, rand64());
      n = $urandom_range(4, 40);
      for (int k = 0; k < n; k++) begin
        put_block(pick64(), pick64(),
                  (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 9) == 0));
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (stim_ops.size() != 0 || in_if.valid || cipher_outs.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
